>>> rtl/core/hbridge_dead_time_sequencer_top_defines.svh
// Assertion macros used by the checker file of the H-bridge sequencer.
// Each macro clocks on aclk. The plain form is disabled while aresetn is low.
// The reset form is not disabled, so it can check the reset behavior itself.
`ifndef HBRIDGE_DEAD_TIME_SEQUENCER_TOP_DEFINES_SVH
`define HBRIDGE_DEAD_TIME_SEQUENCER_TOP_DEFINES_SVH

// Concurrent assertion that is disabled while in reset.
`define HDTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent assertion that is also checked while in reset.
`define HDTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/hdts_pkg.sv
package hdts_pkg;

    // Motor counts: motors that hold state, and motors that appear in a result word.
    localparam int MOTOR_COUNT = 2;
    localparam int OUT_MOTORS  = 2;
    localparam int LIVE_MOTORS = (MOTOR_COUNT < OUT_MOTORS) ? MOTOR_COUNT : OUT_MOTORS;

    // Field and register widths.
    localparam int MODE_W         = 3;
    localparam int POWER_IN_W     = 8;
    localparam int PERIOD_W       = 16;
    localparam int PCT_W          = 7;
    localparam int DEAD_W         = 8;
    localparam int POWER_W        = 16;
    localparam int OP_W           = 2;
    localparam int PROD_W         = PCT_W + PERIOD_W;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int MOTOR_FIELDS_W = OP_W + 2 * POWER_W + 2;

    // Division by 100 as a multiplication by an exact reciprocal.
    // For any product below 2**23, (p * RECIP) >> 30 equals p / 100.
    localparam int                DIV100_SHIFT = 30;
    localparam int                RECIP_W      = 24;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;

    // Configuration reset values and the percent ceiling.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd9000;
    localparam logic [PCT_W-1:0]    MAX_PCT_RESET = 7'd100;
    localparam logic [DEAD_W-1:0]   DEAD_RESET    = 8'd5;
    localparam logic [PCT_W-1:0]    PCT_FULL      = 7'd100;

    // Target power after reset: half scale of the reset period.
    localparam logic [POWER_W-1:0]  TARGET_RESET  = POWER_W'(50 * 9000 / 100);

    // Input word kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 3'd0,
        MODE_FWD   = 3'd1,
        MODE_BWD   = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_BRAKE = 3'd4,
        MODE_POWER = 3'd5
    } mode_t;

    // Bridge operations.
    typedef enum logic [OP_W-1:0] {
        OP_STOP  = 2'd0,
        OP_FWD   = 2'd1,
        OP_BWD   = 2'd2,
        OP_BRAKE = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_MAX_POWER  = 2'd1,
        CFG_DEAD_TIME  = 2'd2
    } cfg_idx_t;

    // Registered command handed from the input stage to the motor records.
    typedef struct packed {
        mode_t              mode;
        logic               motor_index;
        logic [POWER_W-1:0] target;
    } cmd_t;

    // Motor state as it stands after the current word.
    typedef struct packed {
        op_t                op;
        logic [POWER_W-1:0] applied;
    } motor_view_t;

endpackage

>>> rtl/core/hdts_cmd_stage.sv
module hdts_cmd_stage
    import hdts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     in_mode,
    input  logic                  in_motor_index,
    input  logic signed [POWER_IN_W-1:0] in_power_percent,
    input  logic [PERIOD_W-1:0]   pwm_period,
    input  logic [PCT_W-1:0]      max_power_percent,
    output logic                  cmd_valid,
    input  logic                  cmd_take,
    output cmd_t                  cmd
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [MODE_W-1:0]    mode_reg;
    logic                 index_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [PROD_W-1:0]    product_next;
    logic [PCT_W-1:0]     limit;
    logic [PCT_W-1:0]     pct;
    logic                 load;
    logic [PROD_W+RECIP_W-1:0] quot_full;

    // The stage takes a new word whenever it is empty or is being emptied.
    assign in_ready = !valid_reg || cmd_take;
    assign load     = in_valid && in_ready;

    // Clamp the requested percent; a negative request scales to zero.
    always_comb begin
        limit = (max_power_percent > PCT_FULL) ? PCT_FULL : max_power_percent;
        if (in_power_percent[POWER_IN_W-1]) begin
            pct = '0;
        end else if (in_power_percent[PCT_W-1:0] > limit) begin
            pct = limit;
        end else begin
            pct = in_power_percent[PCT_W-1:0];
        end
        product_next = {{PERIOD_W{1'b0}}, pct} * {{PCT_W{1'b0}}, pwm_period};
    end

    assign valid_next = load || (valid_reg && !cmd_take);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Word payload and the scaled product.
    always_ff @(posedge aclk) begin
        if (load) begin
            mode_reg    <= in_mode;
            index_reg   <= in_motor_index;
            product_reg <= product_next;
        end
    end

    // Divide the registered product by 100 through the reciprocal.
    assign quot_full = {{RECIP_W{1'b0}}, product_reg} * {{PROD_W{1'b0}}, DIV100_RECIP};

    assign cmd_valid       = valid_reg;
    assign cmd.mode        = mode_t'(mode_reg);
    assign cmd.motor_index = index_reg;
    assign cmd.target      = quot_full[DIV100_SHIFT +: POWER_W];

endmodule

>>> rtl/core/hdts_motor.sv
module hdts_motor
    import hdts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              upd,
    input  cmd_t              cmd,
    input  logic              sel,
    input  logic [DEAD_W-1:0] dead_time_ms,
    output motor_view_t       view
);

    op_t                cur_reg;
    op_t                cur_next;
    op_t                req_reg;
    op_t                req_next;
    logic [DEAD_W-1:0]  cnt_reg;
    logic [DEAD_W-1:0]  cnt_next;
    logic [POWER_W-1:0] applied_reg;
    logic [POWER_W-1:0] applied_next;
    logic [POWER_W-1:0] target_reg;
    logic [POWER_W-1:0] target_next;
    op_t                req_op;
    logic [DEAD_W-1:0]  load_val;

    // Operation asked for by a direction or brake command, and its dead time.
    always_comb begin
        req_op   = OP_STOP;
        load_val = dead_time_ms;
        case (cmd.mode)
            MODE_FWD: begin
                req_op   = OP_FWD;
                load_val = dead_time_ms + 8'd1;
            end
            MODE_BWD: begin
                req_op   = OP_BWD;
                load_val = dead_time_ms + 8'd1;
            end
            MODE_BRAKE: begin
                req_op   = OP_BRAKE;
                load_val = dead_time_ms;
            end
            default: ;
        endcase
    end

    // State update for one word.
    always_comb begin
        cur_next     = cur_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        applied_next = applied_reg;
        target_next  = target_reg;
        if (upd) begin
            case (cmd.mode)
                MODE_TICK: begin
                    // Count down the dead time; the counter wraps at 8 bits.
                    if (cur_reg != req_reg) begin
                        cnt_next = cnt_reg - 8'd1;
                        if (cnt_next == '0) begin
                            cur_next     = req_reg;
                            applied_next = '0;
                        end
                    end
                    // A running bridge follows the target power.
                    if (cur_next inside {OP_FWD, OP_BWD}) begin
                        applied_next = target_reg;
                    end
                end
                MODE_FWD, MODE_BWD, MODE_BRAKE: begin
                    // A new operation stops the bridge and arms the dead time.
                    if (sel && (req_reg != req_op)) begin
                        cur_next     = OP_STOP;
                        applied_next = '0;
                        cnt_next     = load_val;
                        req_next     = req_op;
                    end
                end
                MODE_STOP: begin
                    if (sel) begin
                        cur_next     = OP_STOP;
                        applied_next = '0;
                        req_next     = OP_STOP;
                    end
                end
                MODE_POWER: begin
                    if (sel) begin
                        target_next = cmd.target;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= OP_STOP;
            req_reg     <= OP_STOP;
            cnt_reg     <= '0;
            applied_reg <= '0;
            target_reg  <= TARGET_RESET;
        end else begin
            cur_reg     <= cur_next;
            req_reg     <= req_next;
            cnt_reg     <= cnt_next;
            applied_reg <= applied_next;
            target_reg  <= target_next;
        end
    end

    assign view.op      = cur_next;
    assign view.applied = applied_next;

endmodule

>>> rtl/core/hbridge_dead_time_sequencer_top.sv
// Channel   Direction  tdata                        tuser
// s_        in         [7:0] power_percent          [2:0] mode, [3] motor_index
// m_        out        72 bits, see the port list   -
// cfg_      in         write enable, index, data    -
//
// One word is accepted per cycle while s_tready is high. Each word passes through the input
// register (clamp and percent-times-period multiply) and then the result register
// (divide-by-100 multiply and motor record update).
// aresetn is synchronous; it restores the register defaults and both motor records.
// While the result register holds a word that is not taken, the input register
// still fills once before s_tready drops.
module hbridge_dead_time_sequencer_top
    import hdts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input words.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] power_percent
    input  logic [3:0]            s_tuser,   // [2:0] mode, [3] motor_index
    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] m0_operation, [17:2] m0_compare_a, [33:18] m0_compare_b, [34] m0_low_a,
    // [35] m0_low_b, [37:36] m1_operation, [53:38] m1_compare_a,
    // [69:54] m1_compare_b, [70] m1_low_a, [71] m1_low_b
    output logic [71:0]           m_tdata,
    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PCT_W-1:0]    max_pct_reg;
    logic [DEAD_W-1:0]   dead_reg;
    logic                cmd_valid;
    logic                adv;
    cmd_t                cmd;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [71:0]         m_data_reg;
    logic [MOTOR_FIELDS_W-1:0] res_fields [OUT_MOTORS];

    // Output fields of one motor from its operation and applied power.
    function automatic logic [MOTOR_FIELDS_W-1:0] pack_motor(motor_view_t v);
        logic [POWER_W-1:0] ca;
        logic [POWER_W-1:0] cb;
        logic               la;
        logic               lb;
        ca = '0;
        cb = '0;
        la = 1'b0;
        lb = 1'b0;
        case (v.op)
            OP_STOP: begin
                la = 1'b1;
                lb = 1'b1;
            end
            OP_FWD: begin
                lb = 1'b1;
                cb = v.applied;
            end
            OP_BWD: begin
                la = 1'b1;
                ca = v.applied;
            end
            OP_BRAKE: ;
            default: ;
        endcase
        return {lb, la, cb, ca, v.op};
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            max_pct_reg <= MAX_PCT_RESET;
            dead_reg    <= DEAD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PWM_PERIOD: period_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_MAX_POWER:  max_pct_reg <= cfg_wdata[PCT_W-1:0];
                CFG_DEAD_TIME:  dead_reg    <= cfg_wdata[DEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register with the power scaling.
    hdts_cmd_stage u_cmd_stage (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_mode           (s_tuser[MODE_W-1:0]),
        .in_motor_index    (s_tuser[MODE_W]),
        .in_power_percent  (s_tdata),
        .pwm_period        (period_reg),
        .max_power_percent (max_pct_reg),
        .cmd_valid         (cmd_valid),
        .cmd_take          (adv),
        .cmd               (cmd)
    );

    // A command moves on when the result register is free or being emptied.
    assign adv = cmd_valid && (!m_valid_reg || m_tready);

    // Motor records; a motor that is not built reports all zeros.
    for (genvar m = 0; m < OUT_MOTORS; m++) begin : g_motor
        if (m < LIVE_MOTORS) begin : g_live
            motor_view_t view;

            hdts_motor u_motor (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .upd          (adv),
                .cmd          (cmd),
                .sel          (cmd.motor_index == 1'(m)),
                .dead_time_ms (dead_reg),
                .view         (view)
            );

            assign res_fields[m] = pack_motor(view);
        end else begin : g_absent
            assign res_fields[m] = '0;
        end
    end

    // Result register.
    assign m_valid_next = adv || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {res_fields[1], res_fields[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/core/hdts_checker.sv
`include "hbridge_dead_time_sequencer_top_defines.svh"

module hdts_checker
    import hdts_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic [MOTOR_FIELDS_W-1:0] f0;
    logic [MOTOR_FIELDS_W-1:0] f1;
    logic                      ok0;
    logic                      ok1;

    // Pin levels and compare values must agree with the reported operation.
    function automatic logic fields_ok(logic [MOTOR_FIELDS_W-1:0] f);
        logic [OP_W-1:0]    op;
        logic [POWER_W-1:0] ca;
        logic [POWER_W-1:0] cb;
        logic               la;
        logic               lb;
        op = f[OP_W-1:0];
        ca = f[OP_W +: POWER_W];
        cb = f[OP_W+POWER_W +: POWER_W];
        la = f[OP_W+2*POWER_W];
        lb = f[OP_W+2*POWER_W+1];
        return (f == '0)
            || ((op == OP_STOP) && (ca == '0) && (cb == '0) && la && lb)
            || ((op == OP_FWD) && (ca == '0) && !la && lb)
            || ((op == OP_BWD) && (cb == '0) && la && !lb)
            || ((op == OP_BRAKE) && (ca == '0) && (cb == '0) && !la && !lb);
    endfunction

    assign f0  = m_tdata[MOTOR_FIELDS_W-1:0];
    assign f1  = m_tdata[2*MOTOR_FIELDS_W-1:MOTOR_FIELDS_W];
    assign ok0 = fields_ok(f0);
    assign ok1 = fields_ok(f1);

    `HDTS_ASSERT(a_motor0_pins, m_tvalid |-> ok0, "motor 0 pins disagree with operation")
    `HDTS_ASSERT(a_motor1_pins, m_tvalid |-> ok1, "motor 1 pins disagree with operation")
    `HDTS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `HDTS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")

endmodule

bind hbridge_dead_time_sequencer_top hdts_checker u_hdts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
